// ===== rtl/mtep_pkg.sv =====
`default_nettype none

package mtep_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned DeltaW = 28;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 2;
  localparam int unsigned DataW  = 7;

  localparam logic [ByteW-1:0]  META_STATUS  = 8'hFF;
  localparam logic [ByteW-1:0]  META_EOT     = 8'h2F;
  localparam logic [NibW-1:0]   ST_NOTE_OFF  = 4'h8;
  localparam logic [NibW-1:0]   ST_NOTE_ON   = 4'h9;
  localparam logic [NibW-1:0]   ST_PROGRAM   = 4'hC;
  localparam logic [NibW-1:0]   ST_PRESSURE  = 4'hD;
  localparam logic [CountW-1:0] DELTA_LAST   = 2'd3;
  localparam logic [ByteW-1:0]  SKIP_ONE     = 8'd1;
  localparam logic [ByteW-1:0]  SKIP_TWO     = 8'd2;
  localparam logic [ScaleW-1:0] US_PER_TICK_RESET = 16'd500;

  typedef struct packed {
    logic              adv;
    logic              emit;
    logic              eot;
    logic              clr;
    logic              note_on;
    logic [ByteW-1:0]  data1;
    logic [ByteW-1:0]  data2;
    logic [DeltaW-1:0] delta;
    logic [ScaleW-1:0] scale;
  } ev_t;

  typedef struct packed {
    logic              adv;
    logic              emit;
    logic              eot;
    logic              clr;
    logic              note_on;
    logic [ByteW-1:0]  data1;
    logic [ByteW-1:0]  data2;
    logic [TimeW-1:0]  delay;
  } sev_t;

endpackage

`default_nettype wire

// ===== rtl/mtep_parser.sv =====
`default_nettype none

module mtep_parser
  import mtep_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire logic [ByteW-1:0]  in_track_byte,
  input  wire logic              in_restart,
  input  wire logic [ScaleW-1:0] us_per_tick,
  output ev_t                    ev
);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_META_TYPE,
    PH_META_LEN,
    PH_SKIP,
    PH_NOTE1,
    PH_NOTE2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [DeltaW-1:0] acc_r, acc_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [NibW-1:0]   nib_r, nib_nxt;
  logic [ByteW-1:0]  held_r, held_nxt;
  logic [ByteW-1:0]  skip_r, skip_nxt;
  logic              done_r, done_nxt;
  ev_t               ev_r, ev_c;
  logic              accept;

  assign accept = in_valid && advance;
  assign ev     = ev_r;

  always_comb begin
    phase_t            phase_e;
    logic [DeltaW-1:0] acc_e;
    logic [CountW-1:0] cnt_e;
    logic [NibW-1:0]   nib_e;
    logic [ByteW-1:0]  held_e;
    logic [ByteW-1:0]  skip_e;
    logic              done_e;
    phase_e = phase_r;
    acc_e   = acc_r;
    cnt_e   = cnt_r;
    nib_e   = nib_r;
    held_e  = held_r;
    skip_e  = skip_r;
    done_e  = done_r;
    if (in_restart) begin
      phase_e = PH_DELTA;
      acc_e   = '0;
      cnt_e   = '0;
      nib_e   = '0;
      held_e  = '0;
      skip_e  = '0;
      done_e  = 1'b0;
    end
    phase_nxt = phase_e;
    acc_nxt   = acc_e;
    cnt_nxt   = cnt_e;
    nib_nxt   = nib_e;
    held_nxt  = held_e;
    skip_nxt  = skip_e;
    done_nxt  = done_e;
    ev_c       = '0;
    ev_c.clr   = in_restart;
    ev_c.delta = acc_e;
    ev_c.scale = us_per_tick;
    if (!done_e) begin
      unique case (phase_e)
        PH_STATUS: begin
          if (in_track_byte == META_STATUS) begin
            phase_nxt = PH_META_TYPE;
          end else begin
            nib_nxt = in_track_byte[ByteW-1 -: NibW];
            if (nib_nxt == ST_NOTE_OFF || nib_nxt == ST_NOTE_ON) begin
              phase_nxt = PH_NOTE1;
            end else begin
              ev_c.adv  = 1'b1;
              skip_nxt  = (nib_nxt == ST_PROGRAM || nib_nxt == ST_PRESSURE) ?
                          SKIP_ONE : SKIP_TWO;
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_META_TYPE: begin
          if (in_track_byte == META_EOT) begin
            ev_c.adv  = 1'b1;
            ev_c.emit = 1'b1;
            ev_c.eot  = 1'b1;
            done_nxt  = 1'b1;
          end else begin
            phase_nxt = PH_META_LEN;
          end
        end
        PH_META_LEN: begin
          ev_c.adv = 1'b1;
          skip_nxt = in_track_byte;
          if (in_track_byte == '0) begin
            phase_nxt = PH_DELTA;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_e - SKIP_ONE;
          if (skip_nxt == '0) begin
            phase_nxt = PH_DELTA;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
        PH_NOTE1: begin
          held_nxt  = in_track_byte;
          phase_nxt = PH_NOTE2;
        end
        PH_NOTE2: begin
          ev_c.adv     = 1'b1;
          ev_c.emit    = 1'b1;
          ev_c.note_on = (nib_e == ST_NOTE_ON);
          ev_c.data1   = held_e;
          ev_c.data2   = in_track_byte;
          phase_nxt    = PH_DELTA;
          acc_nxt      = '0;
          cnt_nxt      = '0;
        end
        default: begin
          acc_nxt = {acc_e[DeltaW-DataW-1:0], in_track_byte[DataW-1:0]};
          if (in_track_byte[ByteW-1] && cnt_e < DELTA_LAST) begin
            cnt_nxt   = cnt_e + 1'b1;
            phase_nxt = PH_DELTA;
          end else begin
            phase_nxt = PH_STATUS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      acc_r   <= '0;
      cnt_r   <= '0;
      nib_r   <= '0;
      held_r  <= '0;
      skip_r  <= '0;
      done_r  <= 1'b0;
      ev_r    <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        nib_r   <= nib_nxt;
        held_r  <= held_nxt;
        skip_r  <= skip_nxt;
        done_r  <= done_nxt;
      end
      if (advance) begin
        ev_r <= accept ? ev_c : '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtep_scale.sv =====
`default_nettype none

module mtep_scale
  import mtep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  input  wire ev_t  ev,
  output sev_t      sev
);

  sev_t                     sev_r;
  logic [DeltaW+ScaleW-1:0] prod;

  assign prod = ev.delta * ev.scale;
  assign sev  = sev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sev_r <= '0;
    end else if (advance) begin
      sev_r.adv     <= ev.adv;
      sev_r.emit    <= ev.emit;
      sev_r.eot     <= ev.eot;
      sev_r.clr     <= ev.clr;
      sev_r.note_on <= ev.note_on;
      sev_r.data1   <= ev.data1;
      sev_r.data2   <= ev.data2;
      sev_r.delay   <= prod[TimeW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtep_timer.sv =====
`default_nettype none

module mtep_timer
  import mtep_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire sev_t             sev,
  output logic                  out_valid,
  output logic                  out_note_on,
  output logic [ByteW-1:0]      out_first_data,
  output logic [ByteW-1:0]      out_second_data,
  output logic [TimeW-1:0]      out_delay_us,
  output logic [TimeW-1:0]      out_at_time_us,
  output logic                  out_end_of_track
);

  logic [TimeW-1:0] time_r, time_nxt, time_base;
  logic             valid_r;
  logic             note_on_r, eot_r;
  logic [ByteW-1:0] data1_r, data2_r;
  logic [TimeW-1:0] delay_r, at_r;

  always_comb begin
    time_base = sev.clr ? '0 : time_r;
    time_nxt  = sev.adv ? time_base + sev.delay : time_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      valid_r <= 1'b0;
    end else if (advance) begin
      time_r  <= time_nxt;
      valid_r <= sev.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      note_on_r <= sev.note_on;
      eot_r     <= sev.eot;
      data1_r   <= sev.data1;
      data2_r   <= sev.data2;
      delay_r   <= sev.delay;
      at_r      <= time_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_note_on      = note_on_r;
  assign out_first_data   = data1_r;
  assign out_second_data  = data2_r;
  assign out_delay_us     = delay_r;
  assign out_at_time_us   = at_r;
  assign out_end_of_track = eot_r;

endmodule

`default_nettype wire

// ===== rtl/midi_track_event_parser_unit.sv =====
// A note or end-of-track transaction is registered in the parser, then the scale stage, then the timer.
// Throughput: one track byte per cycle unless stalled, set by the three-stage parse, scale and time pipeline.
// The pipeline stalls as a whole while a result waits on out_ready.
// Reset (rst_n low at a clock edge) clears the parser, the time total, the scale stage and the
// output valid flag, and loads us_per_tick with 500.
`default_nettype none

module midi_track_event_parser_unit
  import mtep_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ScaleW-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ByteW-1:0]  in_track_byte,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_note_on,
  output logic [ByteW-1:0]       out_first_data,
  output logic [ByteW-1:0]       out_second_data,
  output logic [TimeW-1:0]       out_delay_us,
  output logic [TimeW-1:0]       out_at_time_us,
  output logic                   out_end_of_track
);

  logic [ScaleW-1:0] us_per_tick_r;
  logic              advance;
  ev_t               ev;
  sev_t              sev;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_per_tick_r <= US_PER_TICK_RESET;
    end else if (cfg_wr_en) begin
      us_per_tick_r <= cfg_wr_data;
    end
  end

  mtep_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .in_valid      (in_valid),
    .in_track_byte (in_track_byte),
    .in_restart    (in_restart),
    .us_per_tick   (us_per_tick_r),
    .ev            (ev)
  );

  mtep_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ev      (ev),
    .sev     (sev)
  );

  mtep_timer u_timer (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .sev              (sev),
    .out_valid        (out_valid),
    .out_note_on      (out_note_on),
    .out_first_data   (out_first_data),
    .out_second_data  (out_second_data),
    .out_delay_us     (out_delay_us),
    .out_at_time_us   (out_at_time_us),
    .out_end_of_track (out_end_of_track)
  );

`ifndef ASSERT_OFF
  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ev.emit |-> ev.adv)
    else $error("event emitted without advancing time");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(sev))
    else $error("scale stage moved during an output stall");

  a_eot_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_track) |->
      (!out_note_on && out_first_data == '0 && out_second_data == '0))
    else $error("end of track transaction carries note data");
`endif

endmodule

`default_nettype wire
